>>> sv/rfalu_pkg.sv
// rfalu_pkg: shared types and codes for the rational fraction ALU.
// No dependencies; imported by rfalu_reduce, rational_fraction_alu_core and the testbench.
`default_nettype none

package rfalu_pkg;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic {
        STATUS_OK,
        STATUS_UNDEF
    } status_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] a_num;
        logic signed [15:0] a_den;
        logic signed [15:0] b_num;
        logic signed [15:0] b_den;
    } req_word_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic        [30:0] res_den;
        status_t            status;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ABS,
        ST_RED,
        ST_OUT
    } core_state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_GCD,
        RS_DIVN,
        RS_DIVD
    } red_state_t;

endpackage

`default_nettype wire

>>> sv/rfalu_reduce.sv
// rfalu_reduce: binary GCD and two exact restoring divisions over one subtractor.
// Depends on rfalu_pkg.
`default_nettype none

module rfalu_reduce #(
    parameter int NW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num_mag,
    input  wire logic [NW-1:0] den_mag,
    output logic               done,
    output logic      [NW-1:0] red_num,
    output logic      [NW-1:0] red_den
);
    import rfalu_pkg::*;

    localparam int CW = $clog2(NW);

    red_state_t      state_reg, state_next;
    logic            done_reg, done_next;
    logic [NW-1:0]   u_reg, u_next;
    logic [NW-1:0]   v_reg, v_next;
    logic [NW-1:0]   ns_reg, ns_next;
    logic [NW-1:0]   ds_reg, ds_next;
    logic [NW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [NW-1:0]   rnum_reg, rnum_next;
    logic [NW-1:0]   rden_reg, rden_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic [NW:0]     shifted;
    logic [NW:0]     sub_a;
    logic [NW:0]     sub_b;
    logic [NW+1:0]   diff;
    logic            borrow;
    logic            qbit;

    // shared subtractor
    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign sub_a   = (state_reg == RS_GCD) ? {1'b0, v_reg} : shifted;
    assign sub_b   = {1'b0, u_reg};
    assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow  = diff[NW+1];

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        u_next     = u_reg;
        v_next     = v_reg;
        ns_next    = ns_reg;
        ds_next    = ds_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        rnum_next  = rnum_reg;
        rden_next  = rden_reg;
        cnt_next   = cnt_reg;
        qbit       = ~borrow;
        unique case (state_reg)
            RS_IDLE:
            begin
                if (start)
                begin
                    u_next     = num_mag;
                    v_next     = den_mag;
                    ns_next    = num_mag;
                    ds_next    = den_mag;
                    state_next = RS_GCD;
                end
            end
            RS_GCD:
            begin
                if (v_reg == '0)
                begin
                    rem_next   = '0;
                    quo_next   = ns_reg;
                    cnt_next   = '0;
                    state_next = RS_DIVN;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    // common factor of two comes off the operands too
                    u_next  = u_reg >> 1;
                    v_next  = v_reg >> 1;
                    ns_next = ns_reg >> 1;
                    ds_next = ds_reg >> 1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (!borrow)
                begin
                    v_next = diff[NW-1:0];
                end
                else
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            RS_DIVN, RS_DIVD:
            begin
                if (qbit)
                    rem_next = diff[NW-1:0];
                else
                    rem_next = shifted[NW-1:0];
                quo_next = {quo_reg[NW-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW-1))
                begin
                    if (state_reg == RS_DIVN)
                    begin
                        rnum_next  = quo_next;
                        rem_next   = '0;
                        quo_next   = ds_reg;
                        cnt_next   = '0;
                        state_next = RS_DIVD;
                    end
                    else
                    begin
                        rden_next  = quo_next;
                        done_next  = 1'b1;
                        state_next = RS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        ns_reg   <= ns_next;
        ds_reg   <= ds_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
        cnt_reg  <= cnt_next;
    end

    assign done    = done_reg;
    assign red_num = rnum_reg;
    assign red_den = rden_reg;

endmodule

`default_nettype wire

>>> sv/rational_fraction_alu_core.sv
// rational_fraction_alu_core: top level of the rational fraction ALU.
// Depends on rfalu_pkg and rfalu_reduce.
//
// Usage: a request word carries op and two fractions a_num/a_den, b_num/b_den;
// the response word carries the reduced res_num/res_den and status. Both
// channels are valid/ready; a word moves when valid and ready are high together.
// The block works on one request at a time: req_ready is high only while idle.
// An undefined input (zero denominator, or divide by a zero fraction) goes straight
// to the output state. A zero numerator of the result skips the reduction.
// Otherwise the states ST_MUL1, ST_MUL2 and ST_MUL3 use the one shared multiplier,
// a sign fix-up follows, then the reduction: binary GCD at one shift, subtract or
// swap per cycle and two exact divisions of 2W quotient bits each (W =
// OPERAND_WIDTH), all on one subtractor.
// A finished response sits in an output register; a new request is taken while
// it waits, and a stalled receiver only holds back the next response.
// Reset clears the sequencer and drops any word in flight.
`default_nettype none

module rational_fraction_alu_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire rfalu_pkg::req_word_t req_word,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rfalu_pkg::rsp_word_t      rsp_word
);
    import rfalu_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int NW = 2 * W;
    localparam int AW = NW + 2;
    localparam int RW = (W > 16) ? W : 16;
    localparam int XW = (NW > 32) ? NW : 32;

    core_state_t        state_reg, state_next;
    op_t                op_reg, op_next;
    logic [W:0]         an_reg, an_next;
    logic [W:0]         ad_reg, ad_next;
    logic [W:0]         bn_reg, bn_next;
    logic [W:0]         bd_reg, bd_next;
    logic signed [NW:0] p1_reg, p1_next;
    logic signed [NW:0] p2_reg, p2_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [NW-1:0]      den_reg, den_next;
    logic               den_neg_reg, den_neg_next;
    logic               num_neg_reg, num_neg_next;
    rsp_word_t          res_reg, res_next;
    rsp_word_t          rsp_word_reg, rsp_word_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [W:0]         in_an, in_ad, in_bn, in_bd;
    logic               in_undef;
    logic [W-1:0]       mul_a, mul_b;
    logic               mul_neg;
    logic [NW-1:0]      prod;
    logic signed [NW:0] sprod;
    logic signed [AW-1:0] acc_abs;
    logic [NW-1:0]      num_mag;
    logic               red_start;
    logic               red_done;
    logic [NW-1:0]      red_num, red_den;
    logic [XW-1:0]      nm_x, sn_x, dm_x;
    logic               load_out;

    // operand as {sign, magnitude}
    function automatic logic [W:0] read_op(input logic [15:0] raw);
        logic [RW-1:0] ext;
        logic [W-1:0]  v;
        ext = RW'(raw);
        v   = ext[W-1:0];
        return {v[W-1], (v[W-1] ? (~v + 1'b1) : v)};
    endfunction

    assign in_an = read_op(req_word.a_num);
    assign in_ad = read_op(req_word.a_den);
    assign in_bn = read_op(req_word.b_num);
    assign in_bd = read_op(req_word.b_den);
    assign in_undef = (in_ad[W-1:0] == '0) || (in_bd[W-1:0] == '0)
                   || ((req_word.op == OP_DIV) && (in_bn[W-1:0] == '0));

    // shared multiplier operand select
    always_comb
    begin
        mul_a   = ad_reg[W-1:0];
        mul_b   = bn_reg[W-1:0];
        mul_neg = ad_reg[W] ^ bn_reg[W] ^ (op_reg == OP_SUB);
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = an_reg[W-1:0];
                if (op_reg == OP_MUL)
                begin
                    mul_b   = bn_reg[W-1:0];
                    mul_neg = an_reg[W] ^ bn_reg[W];
                end
                else
                begin
                    mul_b   = bd_reg[W-1:0];
                    mul_neg = an_reg[W] ^ bd_reg[W];
                end
            end
            ST_MUL3:
            begin
                if (op_reg == OP_DIV)
                begin
                    mul_b   = bn_reg[W-1:0];
                    mul_neg = ad_reg[W] ^ bn_reg[W];
                end
                else
                begin
                    mul_b   = bd_reg[W-1:0];
                    mul_neg = ad_reg[W] ^ bd_reg[W];
                end
            end
            default:
            begin
                mul_a = ad_reg[W-1:0];
            end
        endcase
    end

    assign prod  = NW'(mul_a) * NW'(mul_b);
    assign sprod = mul_neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

    assign acc_abs = acc_reg[AW-1] ? -acc_reg : acc_reg;
    assign num_mag = acc_abs[NW-1:0];

    assign nm_x = XW'(red_num);
    assign dm_x = XW'(red_den);
    assign sn_x = (num_neg_reg ^ den_neg_reg) ? (~nm_x + 1'b1) : nm_x;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        an_next       = an_reg;
        ad_next       = ad_reg;
        bn_next       = bn_reg;
        bd_next       = bd_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        den_neg_next  = den_neg_reg;
        num_neg_next  = num_neg_reg;
        res_next      = res_reg;
        req_ready     = 1'b0;
        red_start     = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next = req_word.op;
                    an_next = in_an;
                    ad_next = in_ad;
                    bn_next = in_bn;
                    bd_next = in_bd;
                    if (in_undef)
                    begin
                        res_next.res_num = '0;
                        res_next.res_den = '0;
                        res_next.status  = STATUS_UNDEF;
                        state_next       = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                p1_next    = sprod;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if ((op_reg == OP_ADD) || (op_reg == OP_SUB))
                    p2_next = sprod;
                else
                    p2_next = '0;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                den_next     = prod;
                den_neg_next = mul_neg;
                acc_next     = AW'(p1_reg) + AW'(p2_reg);
                state_next   = ST_ABS;
            end
            ST_ABS:
            begin
                num_neg_next = acc_reg[AW-1];
                if (num_mag == '0)
                begin
                    res_next.res_num = '0;
                    res_next.res_den = 31'd1;
                    res_next.status  = STATUS_OK;
                    state_next       = ST_OUT;
                end
                else
                begin
                    red_start  = 1'b1;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (red_done)
                begin
                    res_next.res_num = sn_x[31:0];
                    res_next.res_den = dm_x[30:0];
                    res_next.status  = STATUS_OK;
                    state_next       = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_word_next  = res_reg;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    rfalu_reduce #(
        .NW (NW)
    ) u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .num_mag (num_mag),
        .den_mag (den_reg),
        .done    (red_done),
        .red_num (red_num),
        .red_den (red_den)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        an_reg       <= an_next;
        ad_reg       <= ad_next;
        bn_reg       <= bn_next;
        bd_reg       <= bd_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        den_neg_reg  <= den_neg_next;
        num_neg_reg  <= num_neg_next;
        res_reg      <= res_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire

>>> tb/tb_rational_fraction_alu_core.sv
// tb_rational_fraction_alu_core: self-checking bench for the rational fraction ALU.
// Depends on rfalu_pkg and rational_fraction_alu_core; predicts each reduced fraction
// and checks the response words in order under random idling and back-pressure.
`default_nettype none

module tb_rational_fraction_alu_core;
    import rfalu_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req_word  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp_word;

    req_word_t pending_reqs[$];
    rsp_word_t expected_fractions[$];

    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    bit          req_taken     = 1'b0;
    bit          rx_stall_req  = 1'b0;
    int          rx_stall_left = 0;
    bit          failed        = 1'b0;

    rational_fraction_alu_core #(
        .OPERAND_WIDTH(16)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_word (rsp_word)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #24_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Exact products, reduction by gcd, sign onto the numerator.
    function automatic rsp_word_t fraction_result(req_word_t w);
        longint    an;
        longint    ad;
        longint    bn;
        longint    bd;
        longint    num;
        longint    den;
        longint    x;
        longint    y;
        longint    t;
        longint    nm;
        longint    dm;
        longint    n_out;
        rsp_word_t r;
        an = w.a_num;
        ad = w.a_den;
        bn = w.b_num;
        bd = w.b_den;
        case (w.op)
            OP_ADD:
            begin
                num = an * bd + ad * bn;
                den = ad * bd;
            end
            OP_SUB:
            begin
                num = an * bd - ad * bn;
                den = ad * bd;
            end
            OP_MUL:
            begin
                num = an * bn;
                den = ad * bd;
            end
            default:
            begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        if (ad == 0 || bd == 0 || den == 0)
        begin
            r.res_num = '0;
            r.res_den = '0;
            r.status  = STATUS_UNDEF;
            return r;
        end
        if (num == 0)
        begin
            r.res_num = '0;
            r.res_den = 31'd1;
            r.status  = STATUS_OK;
            return r;
        end
        x = abs64(num);
        y = abs64(den);
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = abs64(num) / x;
        dm = abs64(den) / x;
        n_out = ((num < 0) != (den < 0)) ? -nm : nm;
        r.res_num = n_out[31:0];
        r.res_den = dm[30:0];
        r.status  = STATUS_OK;
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                req_word  <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_stall_req)
        begin
            rx_stall_req  = 1'b0;
            rx_stall_left = 3000;
        end
        if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_word_t exp_w;
        if (rst_n && req_valid && req_ready)
        begin
            expected_fractions.push_back(fraction_result(req_word));
            req_taken = 1'b1;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_fractions.size() == 0)
            begin
                $error("response word with none expected: %0d/%0d status %0d",
                       rsp_word.res_num, rsp_word.res_den, rsp_word.status);
                failed = 1'b1;
            end
            else
            begin
                exp_w = expected_fractions.pop_front();
                if (rsp_word.res_num !== exp_w.res_num)
                begin
                    $error("res_num mismatch: expected %0d, actual %0d",
                           exp_w.res_num, rsp_word.res_num);
                    failed = 1'b1;
                end
                if (rsp_word.res_den !== exp_w.res_den)
                begin
                    $error("res_den mismatch: expected %0d, actual %0d",
                           exp_w.res_den, rsp_word.res_den);
                    failed = 1'b1;
                end
                if (rsp_word.status !== exp_w.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_w.status, rsp_word.status);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic add_req(op_t op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
        req_word_t w;
        w.op    = op;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
        pending_reqs.push_back(w);
    endtask

    function automatic logic [15:0] pick_value();
        int sel;
        int t;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'h7fff;
            3:       return 16'h8001;
            4, 5, 6, 7, 8:
            begin
                t = $urandom_range(0, 40);
                return 16'(t - 20);
            end
            9, 10, 11:
            begin
                t = $urandom_range(0, 2000);
                return 16'(t - 1000);
            end
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_den();
        logic [15:0] v;
        if ($urandom_range(0, 19) == 0)
            return 16'h0000;
        v = pick_value();
        while (v == 16'h0000)
            v = pick_value();
        return v;
    endfunction

    task automatic add_random_reqs(int count);
        int          sel;
        logic [15:0] an;
        logic [15:0] ad;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                add_req(op_t'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'($urandom()));
            end
            else if (sel == 1)
            begin
                an = pick_value();
                ad = pick_den();
                add_req(op_t'($urandom_range(0, 3)), an, ad,
                        $urandom_range(0, 1) ? an : -an, ad);
            end
            else
            begin
                add_req(op_t'($urandom_range(0, 3)), pick_value(), pick_den(),
                        pick_value(), pick_den());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_fractions.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        tx_idle_pct = 8;
        rx_idle_pct = 79;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_req(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        add_req(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd3);
        add_req(OP_MUL, 16'd2, 16'd3, 16'd3, 16'd4);
        add_req(OP_DIV, 16'd2, 16'd3, 16'd4, 16'd9);
        add_req(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_req(OP_MUL, 16'h7fff, 16'd1, 16'h7fff, 16'd1);
        add_req(OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
        add_req(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'd1);
        add_req(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        add_req(OP_SUB, 16'd1234, 16'd77, 16'd1234, 16'd77);
        add_req(OP_MUL, 16'd0, 16'd5, 16'd3, 16'd7);
        add_req(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd2);
        add_req(OP_SUB, 16'd1, 16'd2, 16'd3, 16'd0);
        add_req(OP_MUL, 16'd0, 16'd0, 16'd0, 16'd0);
        add_req(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
        add_req(OP_DIV, 16'd0, 16'd4, 16'd0, 16'd5);
        add_req(OP_ADD, 16'd1, 16'hfffe, 16'd1, 16'hfffd);
        add_req(OP_DIV, 16'd5, 16'd7, 16'hfffb, 16'd7);
        add_req(OP_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        add_req(OP_SUB, 16'h8000, 16'hffff, 16'h7fff, 16'd1);
        add_req(OP_DIV, 16'd1, 16'h7fff, 16'h7fff, 16'd1);
        add_req(OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_req(OP_DIV, 16'd0, 16'd3, 16'd5, 16'd7);
        add_req(OP_SUB, 16'h8000, 16'h8001, 16'h7fff, 16'h8000);
        wait_drained();

        rx_stall_req = 1'b1;
        add_random_reqs(500);
        wait_drained();

        tx_idle_pct = 79;
        rx_idle_pct = 8;
        add_random_reqs(450);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_reqs(480);
        wait_drained();

        repeat (300) @(posedge clk);
        if (!failed)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
